// ===== design/u8u16_pkg.sv =====
// Shared types, constants and decode helpers for the UTF-8 to UTF-16 decoder.
`timescale 1ns / 1ps
`default_nettype none

package u8u16_pkg;

    // Output queue geometry: room for two results per accepted byte and some slack.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Byte class masks and match values.
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] CODE_LEAD2 = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] CODE_LEAD3 = 8'hE0;
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] CODE_CONT  = 8'h80;

    // Bytes still owed to the open sequence.
    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;

    // One result item.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        invalid;
        logic        end_of_string;
    } t_result;

    // Sequence state held between bytes.
    typedef struct packed {
        logic [1:0] need;
        logic [9:0] part;
        logic       cont_ok;
    } t_seq;

    // What one byte produces: up to two results and the next sequence state.
    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
        t_seq       seq;
    } t_step;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & MASK_CONT) == CODE_CONT;
    endfunction

    // Decode a byte with no sequence open. Keeps the held payload bits when
    // no new sequence starts, as they are not looked at again.
    function automatic t_step fresh_decode(input logic [7:0] b, input logic last,
                                           input t_seq cur);
        t_step s;
        s.count    = 2'd0;
        s.res0     = '0;
        s.res1     = '0;
        s.seq      = cur;
        s.seq.need = NEED_NONE;
        if (b[7] == 1'b0) begin
            s.count = 2'd1;
            s.res0  = '{code_unit: {8'd0, b}, invalid: 1'b0, end_of_string: last};
        end else if ((b & MASK_LEAD2) == CODE_LEAD2) begin
            if (last) begin
                s.count = 2'd1;
                s.res0  = '{code_unit: 16'd0, invalid: 1'b1, end_of_string: 1'b1};
            end else begin
                s.seq = '{need: NEED_ONE, part: {5'd0, b[4:0]}, cont_ok: 1'b1};
            end
        end else if ((b & MASK_LEAD3) == CODE_LEAD3) begin
            if (last) begin
                s.count = 2'd1;
                s.res0  = '{code_unit: 16'd0, invalid: 1'b1, end_of_string: 1'b1};
            end else begin
                s.seq = '{need: NEED_TWO, part: {6'd0, b[3:0]}, cont_ok: 1'b1};
            end
        end else begin
            s.count = 2'd1;
            s.res0  = '{code_unit: 16'd0, invalid: 1'b1, end_of_string: last};
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== design/u8u16_decode.sv =====
// Per-byte UTF-8 decode with the open-sequence state registers.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_decode (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_accept,
    input  wire  [7:0]             i_byte,
    input  wire                    i_last,
    output u8u16_pkg::t_step       o_step,
    output logic                   o_open
);
    import u8u16_pkg::*;

    t_seq  r_seq;
    t_step n_step;
    t_step w_fresh;
    t_step w_fresh_last;

    // Both fresh decodes are shallow; the cut-short case needs the one with last forced.
    assign w_fresh      = fresh_decode(i_byte, i_last, r_seq);
    assign w_fresh_last = fresh_decode(i_byte, 1'b1, r_seq);

    // Next results and state from the held sequence and the incoming byte.
    always_comb begin
        n_step = w_fresh;
        case (r_seq.need)
            NEED_TWO: begin
                if (i_last) begin
                    // A three-byte lead cut short: invalid slot, then this byte afresh.
                    n_step       = w_fresh_last;
                    n_step.count = 2'd2;
                    n_step.res0  = '{code_unit: 16'd0, invalid: 1'b1, end_of_string: 1'b0};
                    n_step.res1  = w_fresh_last.res0;
                end else begin
                    n_step.count = 2'd0;
                    n_step.seq   = '{need: NEED_ONE,
                                     part: {r_seq.part[3:0], i_byte[5:0]},
                                     cont_ok: is_cont(i_byte)};
                end
            end
            NEED_ONE: begin
                n_step.count    = 2'd1;
                n_step.res1     = '0;
                n_step.seq      = '{need: NEED_NONE, part: r_seq.part, cont_ok: 1'b1};
                if (r_seq.cont_ok && is_cont(i_byte)) begin
                    n_step.res0 = '{code_unit: {r_seq.part, i_byte[5:0]},
                                    invalid: 1'b0, end_of_string: i_last};
                end else begin
                    n_step.res0 = '{code_unit: 16'd0, invalid: 1'b1,
                                    end_of_string: i_last};
                end
            end
            default: begin
                n_step = w_fresh;
            end
        endcase
    end

    // Sequence state moves on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '{need: NEED_NONE, part: 10'd0, cont_ok: 1'b1};
        end else if (i_accept) begin
            r_seq <= n_step.seq;
        end
    end

    assign o_step = n_step;
    assign o_open = (r_seq.need == NEED_ONE) || (r_seq.need == NEED_TWO);

endmodule

`default_nettype wire

// ===== design/u8u16_outq.sv =====
// Small result queue: takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module u8u16_outq (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_write,
    input  u8u16_pkg::t_step                   i_step,
    input  wire                                i_read,
    output u8u16_pkg::t_result                 o_head,
    output logic [u8u16_pkg::QUEUE_AW:0]       o_count
);
    import u8u16_pkg::*;

    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic [QUEUE_AW:0]   w_wr_num;
    logic [QUEUE_AW:0]   w_rd_num;
    logic [QUEUE_AW-1:0] w_wr_ptr1;

    assign w_wr_num  = i_write ? {{(QUEUE_AW - 1){1'b0}}, i_step.count} : '0;
    assign w_rd_num  = {{QUEUE_AW{1'b0}}, i_read};
    assign w_wr_ptr1 = r_wr_ptr + 1'b1;

    // Result storage; the second slot is written only when a byte gives two results.
    always_ff @(posedge i_clk) begin
        if (i_write && (i_step.count != 2'd0)) begin
            r_mem[r_wr_ptr] <= i_step.res0;
        end
        if (i_write && (i_step.count == 2'd2)) begin
            r_mem[w_wr_ptr1] <= i_step.res1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + w_wr_num[QUEUE_AW-1:0];
            r_rd_ptr <= r_rd_ptr + w_rd_num[QUEUE_AW-1:0];
            r_count  <= r_count + w_wr_num - w_rd_num;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== design/utf8_to_utf16_stream_decoder.sv =====
// Top level of the UTF-8 to UTF-16 stream decoder.
//
// Input stream: one UTF-8 byte per transfer in s_axis tdata, with tlast on the
// final byte of a string. Output stream: one UTF-16 code unit per transfer in
// m_axis tdata, tuser set when the slot stands for a malformed sequence (the
// unit is then 0), and tlast on the final result of the string.
// A byte is decoded in the cycle it is accepted and its results sit in a
// four-entry output queue from the next cycle. Throughput is one byte per
// cycle while the input is ready. A byte yields zero, one or two results;
// the output side moves one result per cycle while the receiver is ready, so
// a run of bytes that give two results each is paced by the output port. The
// input is ready while the queue has room for two results.
// Reset (synchronous, active low) empties the queue and closes any open
// sequence; no clearing pass is needed. When the receiver stalls, the queue
// fills and the input deasserts ready; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_utf16_stream_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  wire  [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  wire         i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] code_unit
    output logic        o_m_axis_tuser,   // [0] invalid
    output logic        o_m_axis_tlast
);
    import u8u16_pkg::*;

    t_step               w_step;
    t_result             w_head;
    logic [QUEUE_AW:0]   w_count;
    logic                w_in_xfer;
    logic                w_out_xfer;
    logic                w_open;

    // Room for the worst case of two results per byte.
    assign o_s_axis_tready = (w_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
    assign w_in_xfer       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer      = o_m_axis_tvalid && i_m_axis_tready;

    // Byte decode and sequence state.
    u8u16_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_in_xfer),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_step   (w_step),
        .o_open   (w_open)
    );

    // Result queue towards the output port.
    u8u16_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_write  (w_in_xfer),
        .i_step   (w_step),
        .i_read   (w_out_xfer),
        .o_head   (w_head),
        .o_count  (w_count)
    );

    assign o_m_axis_tvalid = (w_count != '0);
    assign o_m_axis_tdata  = w_head.code_unit;
    assign o_m_axis_tuser  = w_head.invalid;
    assign o_m_axis_tlast  = w_head.end_of_string;

    // The queue never holds more than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("result queue overfilled");

    // A string's final byte always closes any open sequence.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_s_axis_tlast) |=> !w_open)
        else $error("sequence left open after final byte");

    // An invalid slot carries a zero code unit.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == 16'd0))
        else $error("invalid slot with nonzero code unit");

    // An accepted byte that yields a result is visible on the output next cycle.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (w_step.count != 2'd0)) |=> o_m_axis_tvalid)
        else $error("result not presented after decode");

endmodule

`default_nettype wire
